// ----- hdl/zbuffer_span_fill_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Z-buffer span fill: assertion macros
// Shared property wrappers. They drop out of synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ZBUFFER_SPAN_FILL_UNIT_DEFINES_SVH
`define ZBUFFER_SPAN_FILL_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while in reset
`define ZSF_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, sampled on clk, off while in reset
`define ZSF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ZSF_ASSERT_IMPL(lbl, ante, cons, msg)
`define ZSF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- hdl/zsf_pkg.sv -----
// ----------------------------------------------------------------------------
// Z-buffer span fill: shared types and constants
// Span word layout, queue descriptor, state encodings and register indexes.
// ----------------------------------------------------------------------------
package zsf_pkg;

	// Fixed field widths
	localparam int ROW_W    = 8;
	localparam int X_W      = 9;
	localparam int Z_W      = 32;
	localparam int COLOR_W  = 8;
	localparam int COUNT_W  = 9;
	localparam int CFG_W    = 32;

	// Stream word widths
	localparam int IN_W        = ROW_W + 2 * X_W + 2 * Z_W + COLOR_W;
	localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((COUNT_W + 7) / 8) * 8;

	// Step division: depth difference over span length
	localparam int DIFF_W    = Z_W + 1;
	localparam int LEN_W     = X_W + 1;
	localparam int STEP_W    = DIFF_W + 1;
	localparam int DIV_STEPS = DIFF_W;
	localparam int ITER_W    = $clog2(DIV_STEPS);

	// Span queue, power-of-two depth
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_BIAS  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_SHIFT = 1'b1;

	// Input span word, row in the lowest bits
	typedef struct packed {
		logic        [COLOR_W-1:0] color;
		logic signed [Z_W-1:0]     right_depth;
		logic signed [Z_W-1:0]     left_depth;
		logic        [X_W-1:0]     right_x;
		logic        [X_W-1:0]     left_x;
		logic        [ROW_W-1:0]   row;
	} span_in_t;

	// Classified span handed from front to back
	typedef struct packed {
		logic                     empty;
		logic        [ROW_W-1:0]  row;
		logic        [X_W-1:0]    left_x;
		logic        [X_W-1:0]    right_x;
		logic signed [Z_W-1:0]    left_depth;
		logic signed [STEP_W-1:0] step;
		logic        [COLOR_W-1:0] color;
	} span_desc_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_CLEAR,
		B_IDLE,
		B_WALK,
		B_DRAIN,
		B_DONE
	} back_state_t;

endpackage

// ----- hdl/zsf_front.sv -----
// ----------------------------------------------------------------------------
// Z-buffer span fill: front end
// Takes span words, flags empty spans and works out the per-pixel depth step
// with a bit-serial signed divider before queuing the span.
// ----------------------------------------------------------------------------
`include "zbuffer_span_fill_unit_defines.svh"

module zsf_front
	import zsf_pkg::*;
#(
	parameter int SCREEN_ROWS = 200
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        hold,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  span_in_t    span,
	input  queue_stat_t q_stat,
	output logic        push,
	output span_desc_t  desc
);

	front_state_t state_q, state_d;

	logic [ITER_W-1:0]   iter_q;
	logic [LEN_W-1:0]    len_q;
	logic [LEN_W-1:0]    rem_q;
	logic [DIFF_W-1:0]   quo_q;
	logic                neg_q;
	logic                empty_q;
	logic [ROW_W-1:0]    row_q;
	logic [X_W-1:0]      lx_q;
	logic [X_W-1:0]      rx_q;
	logic signed [Z_W-1:0] zl_q;
	logic [COLOR_W-1:0]  color_q;

	logic                s_accept;
	logic                cls_empty;
	logic signed [DIFF_W-1:0] diff;
	logic [DIFF_W-1:0]   diff_mag;
	logic [LEN_W-1:0]    span_len;
	logic [LEN_W:0]      trial;
	logic                trial_ge;
	logic [LEN_W:0]      trial_sub;
	logic [STEP_W-1:0]   quo_ext;

	// Reversed spans and rows below the screen draw nothing
	assign cls_empty = (span.right_x < span.left_x) || (int'(span.row) >= SCREEN_ROWS);
	assign diff      = {span.right_depth[Z_W-1], span.right_depth}
	                 - {span.left_depth[Z_W-1], span.left_depth};
	assign diff_mag  = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;
	assign span_len  = {1'b0, span.right_x} - {1'b0, span.left_x} + LEN_W'(1);

	// One quotient bit a cycle, restoring
	assign trial     = {rem_q, quo_q[DIFF_W-1]};
	assign trial_ge  = trial >= {1'b0, len_q};
	assign trial_sub = trial - {1'b0, len_q};
	assign quo_ext   = {1'b0, quo_q};

	assign s_accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		push     = 1'b0;
		unique case (state_q)
			F_IDLE: begin
				s_tready = !hold;
				if (s_tvalid && !hold) begin
					state_d = cls_empty ? F_PUSH : F_DIV;
				end
			end
			F_DIV: begin
				if (iter_q == ITER_W'(DIV_STEPS - 1)) begin
					state_d = F_PUSH;
				end
			end
			F_PUSH: begin
				push = !q_stat.full;
				if (!q_stat.full) begin
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			empty_q <= cls_empty;
			row_q   <= span.row;
			lx_q    <= span.left_x;
			rx_q    <= span.right_x;
			zl_q    <= span.left_depth;
			color_q <= span.color;
			neg_q   <= diff[DIFF_W-1];
			len_q   <= span_len;
			quo_q   <= diff_mag;
			rem_q   <= '0;
			iter_q  <= '0;
		end else if (state_q == F_DIV) begin
			rem_q  <= trial_ge ? trial_sub[LEN_W-1:0] : trial[LEN_W-1:0];
			quo_q  <= {quo_q[DIFF_W-2:0], trial_ge};
			iter_q <= iter_q + ITER_W'(1);
		end
	end

	always_comb begin
		desc.empty      = empty_q;
		desc.row        = row_q;
		desc.left_x     = lx_q;
		desc.right_x    = rx_q;
		desc.left_depth = zl_q;
		desc.step       = neg_q ? (~quo_ext + STEP_W'(1)) : quo_ext;
		desc.color      = color_q;
	end

	`ZSF_ASSERT_IMPL(a_busy_no_accept, state_q != F_IDLE, !s_tready, "front took a span while busy")
	`ZSF_ASSERT_IMPL(a_push_only_ready, push, (state_q == F_PUSH) && !q_stat.full, "front pushed into a full queue")

endmodule

// ----- hdl/zsf_queue.sv -----
// ----------------------------------------------------------------------------
// Z-buffer span fill: span queue
// Small register queue of classified spans between front and back.
// ----------------------------------------------------------------------------
`include "zbuffer_span_fill_unit_defines.svh"

module zsf_queue
	import zsf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  span_desc_t  push_desc,
	input  logic        pop,
	output span_desc_t  pop_desc,
	output queue_stat_t stat
);

	span_desc_t          slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign stat.full  = count_q == QCNT_W'(QUEUE_DEPTH);
	assign stat.empty = count_q == '0;
	assign pop_desc   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_desc;
		end
	end

	`ZSF_ASSERT_IMPL(a_pop_not_empty, pop, !stat.empty, "pop from an empty span queue")
	`ZSF_ASSERT_NEXT(a_push_fills, push && !pop, !stat.empty, "queue empty after a push")

endmodule

// ----- hdl/zsf_back.sv -----
// ----------------------------------------------------------------------------
// Z-buffer span fill: back end
// Clears the depth and frame stores after reset, then walks queued spans one
// pixel a cycle with a read, compare and write-back of the depth store.
// ----------------------------------------------------------------------------
`include "zbuffer_span_fill_unit_defines.svh"

module zsf_back
	import zsf_pkg::*;
#(
	parameter int SCREEN_COLS = 320,
	parameter int SCREEN_ROWS = 200,
	parameter int DEPTH_BITS  = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	input  span_desc_t              desc,
	input  queue_stat_t             q_stat,
	output logic                    pop,
	output logic                    clear_busy,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [COUNT_W-1:0]      count
);

	localparam int STORE_SIZE = SCREEN_COLS * SCREEN_ROWS;
	localparam int ADDR_W     = $clog2(STORE_SIZE);
	localparam int SUM_W      = ((DEPTH_BITS > Z_W) ? DEPTH_BITS : Z_W) + 2;
	localparam logic signed [SUM_W-1:0] SUM_MAX =
		signed'((SUM_W'(1) << (DEPTH_BITS - 1)) - SUM_W'(1));
	localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_MAX - SUM_W'(1);
	localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {1'b0, {(DEPTH_BITS - 1){1'b1}}};
	localparam logic [DEPTH_BITS-1:0] DEPTH_MIN = {1'b1, {(DEPTH_BITS - 1){1'b0}}};

	back_state_t state_q, state_d;

	// Stores
	logic signed [DEPTH_BITS-1:0] depth_mem [STORE_SIZE];
	logic [COLOR_W-1:0]           frame_mem [STORE_SIZE];
	logic signed [DEPTH_BITS-1:0] rd_q;

	// Control
	logic [ADDR_W-1:0]   clr_q;
	logic                s1_valid_q;
	logic                out_valid_q;
	logic signed [CFG_W-1:0] bias_q;
	logic signed [CFG_W-1:0] shift_q;

	// Span walk
	logic [X_W-1:0]           x_q;
	logic [X_W-1:0]           last_x_q;
	logic signed [Z_W-1:0]    z_q;
	logic signed [STEP_W-1:0] step_q;
	logic [ADDR_W-1:0]        base_q;
	logic [COLOR_W-1:0]       color_q;
	logic [COUNT_W-1:0]       cnt_q;
	logic [COUNT_W-1:0]       out_q;
	logic [ADDR_W-1:0]        addr_s1;
	logic signed [DEPTH_BITS-1:0] d_s1;

	logic [ADDR_W-1:0]        rd_addr;
	logic                     in_cols;
	logic signed [SUM_W-1:0]  sum_w;
	logic signed [DEPTH_BITS-1:0] d_sat;
	logic [STEP_W-1:0]        z_next;
	logic                     commit;
	logic                     mem_we;
	logic [ADDR_W-1:0]        mem_addr;
	logic [DEPTH_BITS-1:0]    mem_depth;
	logic [COLOR_W-1:0]       mem_color;

	assign rd_addr = base_q + ADDR_W'(x_q);
	assign in_cols = int'(x_q) < SCREEN_COLS;
	assign z_next  = {{(STEP_W - Z_W){z_q[Z_W-1]}}, z_q} + step_q;

	// Biased depth, exact, then clamped to the store's range
	assign sum_w = {{(SUM_W - Z_W){z_q[Z_W-1]}}, z_q}
	             + {{(SUM_W - CFG_W){bias_q[CFG_W-1]}}, bias_q}
	             + {{(SUM_W - CFG_W){shift_q[CFG_W-1]}}, shift_q};

	always_comb begin
		if (sum_w > SUM_MAX) begin
			d_sat = DEPTH_MAX;
		end else if (sum_w < SUM_MIN) begin
			d_sat = DEPTH_MIN;
		end else begin
			d_sat = sum_w[DEPTH_BITS-1:0];
		end
	end

	assign commit = s1_valid_q && (d_s1 > rd_q);

	// Single write port shared by the clearing pass and pixel commits
	assign mem_we    = (state_q == B_CLEAR) || commit;
	assign mem_addr  = (state_q == B_CLEAR) ? clr_q : addr_s1;
	assign mem_depth = (state_q == B_CLEAR) ? DEPTH_MIN : d_s1;
	assign mem_color = (state_q == B_CLEAR) ? '0 : color_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			depth_mem[mem_addr] <= mem_depth;
			frame_mem[mem_addr] <= mem_color;
		end
		rd_q <= depth_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		pop        = 1'b0;
		clear_busy = 1'b0;
		unique case (state_q)
			B_CLEAR: begin
				clear_busy = 1'b1;
				if (clr_q == ADDR_W'(STORE_SIZE - 1)) begin
					state_d = B_IDLE;
				end
			end
			B_IDLE: begin
				pop = !q_stat.empty && !out_valid_q;
				if (pop) begin
					state_d = desc.empty ? B_DONE : B_WALK;
				end
			end
			B_WALK: begin
				if (x_q == last_x_q) begin
					state_d = B_DRAIN;
				end
			end
			B_DRAIN: state_d = B_DONE;
			B_DONE:  state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			bias_q      <= '0;
			shift_q     <= '0;
		end else begin
			if (state_q == B_CLEAR) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			s1_valid_q <= (state_q == B_WALK) && in_cols;
			if (state_q == B_DONE) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_DEPTH_BIAS:  bias_q  <= cfg_data;
					CFG_DEPTH_SHIFT: shift_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			x_q      <= desc.left_x;
			last_x_q <= desc.right_x;
			z_q      <= desc.left_depth;
			step_q   <= desc.step;
			base_q   <= ADDR_W'(desc.row) * ADDR_W'(SCREEN_COLS);
			color_q  <= desc.color;
		end else if (state_q == B_WALK) begin
			x_q <= x_q + X_W'(1);
			z_q <= z_next[Z_W-1:0];
		end
		if (state_q == B_WALK) begin
			d_s1    <= d_sat;
			addr_s1 <= rd_addr;
		end
		if (pop) begin
			cnt_q <= '0;
		end else if (commit) begin
			cnt_q <= cnt_q + COUNT_W'(1);
		end
		if (state_q == B_DONE) begin
			out_q <= cnt_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign count    = out_q;

	`ZSF_ASSERT_IMPL(a_no_pop_in_clear, state_q == B_CLEAR, !pop, "span popped during store clear")
	`ZSF_ASSERT_IMPL(a_commit_in_range, commit, int'(addr_s1) < STORE_SIZE, "pixel commit off the store")
	`ZSF_ASSERT_IMPL(a_done_slot_free, state_q == B_DONE, !out_valid_q || m_tready, "result overwrote a waiting count")

endmodule

// ----- hdl/zbuffer_span_fill_unit.sv -----
// ----------------------------------------------------------------------------
// Z-buffer span fill unit
// Draws flat-colored horizontal spans into a depth-tested frame store and
// returns the number of pixels written for each span.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Word                                  Handshake
//  s_*       in         one span: row, x range, depths, color tvalid/tready
//  m_*       out        pixels written for that span          tvalid/tready
//  cfg_*     in         depth_bias / depth_shift write        cfg_we, no wait
//
//  Front: takes no new span until the 33-step serial step divider is done and
//  the span is queued. Back: one pixel a cycle through the depth store read
//  port, plus pop, drain and result load for each span, so the back sets the
//  sustained rate for long spans.
//  After reset both stores are cleared one entry a cycle, all SCREEN_COLS *
//  SCREEN_ROWS entries (64000 at the defaults); s_tready stays low meanwhile.
//  A two-entry span queue lets the divider work ahead while the back walks;
//  a stalled m_tready holds the finished count and blocks only the back.
//
module zbuffer_span_fill_unit
	import zsf_pkg::*;
#(
	parameter int SCREEN_COLS = 320,
	parameter int SCREEN_ROWS = 200,
	parameter int DEPTH_BITS  = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Span input
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// row[7:0], left_x[16:8], right_x[25:17], left_depth[57:26],
	// right_depth[89:58], color[97:90], zero pad [103:98]
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// Count output
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// pixels_written[8:0], zero pad [15:9]
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// Configuration writes
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]       cfg_data
);

	span_in_t    span;
	span_desc_t  push_desc;
	span_desc_t  pop_desc;
	queue_stat_t q_stat;
	logic        push;
	logic        pop;
	logic        clear_busy;
	logic [COUNT_W-1:0] count;

	// Unpack the span word; pad bits above the fields are ignored
	assign span = span_in_t'(s_tdata[IN_W-1:0]);

	// Classify the span and divide out its depth step
	zsf_front #(
		.SCREEN_ROWS (SCREEN_ROWS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.hold     (clear_busy),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.span     (span),
		.q_stat   (q_stat),
		.push     (push),
		.desc     (push_desc)
	);

	// Decouple divider from pixel walk
	zsf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.pop_desc  (pop_desc),
		.stat      (q_stat)
	);

	// Walk pixels against the depth store and hold the count
	zsf_back #(
		.SCREEN_COLS (SCREEN_COLS),
		.SCREEN_ROWS (SCREEN_ROWS),
		.DEPTH_BITS  (DEPTH_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.desc       (pop_desc),
		.q_stat     (q_stat),
		.pop        (pop),
		.clear_busy (clear_busy),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.count      (count)
	);

	// Zero-pad the count to a whole byte
	assign m_tdata = {{(OUT_TDATA_W - COUNT_W){1'b0}}, count};

endmodule
